// File: hw/rtl/mvp_pkg.sv
// shared constants and helpers for the matrix vector product block
package mvp_pkg;

    localparam int MAX_SIZE = 64;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int SIZE_W   = 7;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int SUM_W    = 40;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_MATRIX  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VECTOR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

    // last row/column index in use for a given size register value
    function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] size);
        logic [IDX_W-1:0] idx;
        if (size == '0)
        begin
            idx = '0;
        end
        else if (size > SIZE_W'(MAX_SIZE))
        begin
            idx = IDX_W'(MAX_SIZE - 1);
        end
        else
        begin
            idx = IDX_W'(size - SIZE_W'(1));
        end
        return idx;
    endfunction

endpackage

// File: hw/rtl/matrix_vector_product.sv
// top level: matrix and vector stores with a pipelined multiply-accumulate walk
//
//  channel | direction | handshake              | carries
//  --------+-----------+------------------------+----------------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_data: matrix size
//  in      | in        | in_valid / in_ready    | kind, row, column, value
//  out     | out       | out_valid / out_ready  | row_index, sum, last
//
// element writes go straight into the stores
// a compute item reads one matrix element per cycle from the matrix memory port while the walk is not stalled
// in_ready is low while the reads of a compute are being issued
// a result that waits on out_ready stalls the walk at the row end, nothing is dropped
// reset is asynchronous, active low; the stores hold no reset and need no clearing
module matrix_vector_product (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mvp_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mvp_pkg::KIND_W-1:0]    kind,
    input  logic [mvp_pkg::IDX_W-1:0]     row,
    input  logic [mvp_pkg::IDX_W-1:0]     column,
    input  logic signed [mvp_pkg::ELEM_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mvp_pkg::IDX_W-1:0]     row_index,
    output logic signed [mvp_pkg::SUM_W-1:0] sum,
    output logic                          last
);
    import mvp_pkg::*;

    logic [ELEM_W-1:0] matrix_mem [MAX_SIZE*MAX_SIZE];
    logic [ELEM_W-1:0] vector_mem [MAX_SIZE];

    logic [SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]  n_last_reg;
    logic              issue_reg;
    logic [IDX_W-1:0]  r_reg;
    logic [IDX_W-1:0]  c_reg;

    // stage 1: memory read data
    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_lastcol_reg;
    logic              s1_lastrow_reg;
    logic [IDX_W-1:0]  s1_row_reg;
    logic [ELEM_W-1:0] m_rd_reg;
    logic [ELEM_W-1:0] v_rd_reg;

    // stage 2: product
    logic              s2_valid_reg;
    logic              s2_first_reg;
    logic              s2_lastcol_reg;
    logic              s2_lastrow_reg;
    logic [IDX_W-1:0]  s2_row_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic              out_last_reg;

    logic in_fire;
    logic stall;
    logic load_out;
    logic rd_en;

    assign cfg_ready = 1'b1;
    assign in_ready  = !issue_reg;
    assign in_fire   = in_valid && in_ready;

    // hold the whole walk when a row result has nowhere to go
    assign stall    = s2_valid_reg && s2_lastcol_reg && out_valid_reg && !out_ready;
    assign load_out = s2_valid_reg && s2_lastcol_reg && !stall;
    assign rd_en    = issue_reg && !stall;

    assign acc_next = (s2_first_reg ? SUM_W'(0) : acc_reg)
                    + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // element stores
    always_ff @(posedge clk)
    begin
        if (in_fire && kind == KIND_MATRIX)
        begin
            matrix_mem[{row, column}] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && kind == KIND_VECTOR)
        begin
            vector_mem[column] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            m_rd_reg <= matrix_mem[{r_reg, c_reg}];
            v_rd_reg <= vector_mem[c_reg];
        end
    end

    // read sequencer over rows and columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            r_reg      <= '0;
            c_reg      <= '0;
            n_last_reg <= '0;
        end
        else if (in_fire && kind == KIND_COMPUTE)
        begin
            issue_reg  <= 1'b1;
            r_reg      <= '0;
            c_reg      <= '0;
            n_last_reg <= last_index(size_reg);
        end
        else if (rd_en)
        begin
            if (c_reg == n_last_reg)
            begin
                c_reg <= '0;
                r_reg <= r_reg + IDX_W'(1);
                if (r_reg == n_last_reg)
                begin
                    issue_reg <= 1'b0;
                end
            end
            else
            begin
                c_reg <= c_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= issue_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_first_reg   <= (c_reg == '0);
            s1_lastcol_reg <= (c_reg == n_last_reg);
            s1_lastrow_reg <= (r_reg == n_last_reg);
            s1_row_reg     <= r_reg;
            s2_first_reg   <= s1_first_reg;
            s2_lastcol_reg <= s1_lastcol_reg;
            s2_lastrow_reg <= s1_lastrow_reg;
            s2_row_reg     <= s1_row_reg;
            prod_reg       <= $signed(m_rd_reg) * $signed(v_rd_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && !stall)
        begin
            acc_reg <= acc_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg  <= s2_row_reg;
            out_sum_reg  <= acc_next;
            out_last_reg <= s2_lastrow_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = out_row_reg;
    assign sum       = out_sum_reg;
    assign last      = out_last_reg;

endmodule

// File: hw/rtl/mvp_checker.sv
// port-level checks for the matrix vector product block, bound to the top level
module mvp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mvp_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [mvp_pkg::KIND_W-1:0]    kind,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mvp_pkg::IDX_W-1:0]     row_index,
    input  logic signed [mvp_pkg::SUM_W-1:0] sum,
    input  logic                          last
);
    import mvp_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]  exp_row_reg;
    logic [IDX_W-1:0]  n_last;

    assign n_last = last_index(size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // rows of a result run come out in order from row zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_row_reg <= last ? '0 : row_index + IDX_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum) && $stable(row_index)
                                    && $stable(last))
        else $error("result item changed while stalled");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_index == exp_row_reg)
        else $error("result row out of order");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (row_index == n_last)))
        else $error("last flag does not match final row");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_COMPUTE |=> !in_ready)
        else $error("input taken while a compute starts");

endmodule

bind matrix_vector_product mvp_checker u_mvp_checker (.*);
